/* hdl/grc_pkg.sv */
// Shared types and constants of the grid ray wall caster.
package grc_pkg;
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_CAST  = 1'b1;

	localparam logic [2:0] REG_POS_X   = 3'd0;
	localparam logic [2:0] REG_POS_Y   = 3'd1;
	localparam logic [2:0] REG_DIR_X   = 3'd2;
	localparam logic [2:0] REG_DIR_Y   = 3'd3;
	localparam logic [2:0] REG_PLANE_X = 3'd4;
	localparam logic [2:0] REG_PLANE_Y = 3'd5;

	localparam int FOG_LIN  = 4588;
	localparam int FOG_QUAD = 328;
	localparam int SIDE_DIM = 184;
	localparam int DIST_MAX = 16777215;

	typedef struct packed {
		logic        start;
		logic [63:0] num;
		logic [49:0] den;
	} div_req_t;
endpackage

/* hdl/grc_ram.sv */
// Generic single-port-write, registered-read RAM.
module grc_ram #(
	parameter int WIDTH = 3,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

/* hdl/grc_div.sv */
// Restoring divider, one quotient bit per cycle.
module grc_div (
	input  logic               clk,
	input  logic               arst_n,
	input  grc_pkg::div_req_t  req,
	output logic               done,
	output logic [63:0]        quo
);
	import grc_pkg::*;

	logic [63:0] quo_q;
	logic [49:0] rem_q;
	logic [49:0] den_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic [50:0] trial;

	assign trial = {rem_q, quo_q[63]} - {1'b0, den_q};
	assign quo = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd64;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!trial[50]) begin
				rem_q <= trial[49:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= {rem_q[48:0], quo_q[63]};
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end
endmodule

/* hdl/grid_ray_wall_caster_unit.sv */
// Top level: map memory, ray setup, DDA walk and column shading.
// A write item is accepted in ST_IDLE; the input stays ready for back-to-back writes while no result is pending.
// A cast item runs from accept to result valid through ray setup, a walk of 1..MAX_STEPS map
// steps and shading, with four serial divisions (two step lengths, line height, fog) in the
// shared divider.
// Reset sets the camera registers to defaults and runs a clearing pass over all MAP_W*MAP_H
// cells of the map memory, during which no item is accepted.
module grid_ray_wall_caster_unit #(
	parameter int MAP_W     = 32,
	parameter int MAP_H     = 32,
	parameter int SCREEN_W  = 960,
	parameter int SCREEN_H  = 540,
	parameter int TEX_SIZE  = 64,
	parameter int MAX_STEPS = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [20:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // cell_x, cell_y, cell_type, screen_column, zero pad
	input  logic        s_tuser,   // op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata    // column_out, wall_texture, hit_side, draw_start,
	                               // draw_end, line_height, tex_column, light_level,
	                               // wall_distance, zero pad
);
	import grc_pkg::*;

	localparam int XW = $clog2(MAP_W);
	localparam int YW = $clog2(MAP_H);
	localparam int AW = XW + YW;
	localparam int NCELL = MAP_W * MAP_H;
	localparam int SW = $clog2(MAX_STEPS + 1);
	localparam int TW = $clog2(TEX_SIZE);
	localparam logic [31:0] CAM_RCP = 32'((64'd1 << 32) / SCREEN_W);

	localparam logic [4:0] ST_CLR   = 5'd0;
	localparam logic [4:0] ST_IDLE  = 5'd1;
	localparam logic [4:0] ST_CAM   = 5'd2;
	localparam logic [4:0] ST_RAY   = 5'd3;
	localparam logic [4:0] ST_DDX   = 5'd4;
	localparam logic [4:0] ST_DDY   = 5'd5;
	localparam logic [4:0] ST_SIDE  = 5'd6;
	localparam logic [4:0] ST_STEP  = 5'd7;
	localparam logic [4:0] ST_READ  = 5'd8;
	localparam logic [4:0] ST_DIST  = 5'd9;
	localparam logic [4:0] ST_LH    = 5'd10;
	localparam logic [4:0] ST_FOG1  = 5'd11;
	localparam logic [4:0] ST_FOG2  = 5'd12;
	localparam logic [4:0] ST_FOGD  = 5'd13;
	localparam logic [4:0] ST_OUT   = 5'd14;
	localparam logic [4:0] ST_HIT   = 5'd15;
	localparam logic [4:0] ST_CAMF  = 5'd16;

	logic [4:0] st_q;

	logic [20:0] pos_x_q, pos_y_q;
	logic signed [17:0] dir_x_q, dir_y_q, plane_x_q, plane_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q   <= 21'd163840;
			pos_y_q   <= 21'd819200;
			dir_x_q   <= 18'sd65536;
			dir_y_q   <= 18'sd0;
			plane_x_q <= 18'sd0;
			plane_y_q <= -18'sd43254;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_POS_X:   pos_x_q   <= cfg_data;
				REG_POS_Y:   pos_y_q   <= cfg_data;
				REG_DIR_X:   dir_x_q   <= cfg_data[17:0];
				REG_DIR_Y:   dir_y_q   <= cfg_data[17:0];
				REG_PLANE_X: plane_x_q <= cfg_data[17:0];
				REG_PLANE_Y: plane_y_q <= cfg_data[17:0];
				default: ;
			endcase
		end
	end

	// input fields
	logic [4:0] in_cx, in_cy;
	logic [2:0] in_type;
	logic [9:0] in_col;
	assign in_cx   = s_tdata[4:0];
	assign in_cy   = s_tdata[9:5];
	assign in_type = s_tdata[12:10];
	assign in_col  = s_tdata[22:13];

	// map memory
	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [2:0]    ram_wdata, ram_rdata;
	logic [AW:0]   clr_q;

	grc_ram #(.WIDTH(3), .DEPTH(NCELL)) u_map (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(ram_raddr), .rdata(ram_rdata)
	);

	logic acc;
	assign s_tready = (st_q == ST_IDLE) && !m_tvalid;
	assign acc = s_tvalid && s_tready;

	logic wr_ok;
	assign wr_ok = ({27'd0, in_cx} < MAP_W) && ({27'd0, in_cy} < MAP_H);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = clr_q[AW-1:0];
		ram_wdata = 3'd0;
		if (st_q == ST_CLR) begin
			ram_we = 1'b1;
		end else if (acc && s_tuser == OP_WRITE && wr_ok) begin
			ram_we    = 1'b1;
			ram_waddr = AW'((32'(in_cy) * MAP_W) + 32'(in_cx));
			ram_wdata = in_type;
		end
	end

	// divider
	div_req_t dreq;
	logic     ddone;
	logic [63:0] dquo;

	grc_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .done(ddone), .quo(dquo));

	// datapath registers
	logic [9:0]         col_q;
	logic               dstart_q;
	logic [28:0]        camq0_q;
	logic signed [17:0] cam_q;
	logic signed [19:0] rx_q, ry_q;
	logic [48:0]        ddx_q, ddy_q;
	logic [56:0]        sdx_q, sdy_q;
	logic signed [9:0]  mx_q, my_q;
	logic               side_q;
	logic [2:0]         type_q;
	logic [SW-1:0]      steps_q;
	logic [23:0]        d_q;
	logic [15:0]        lh_q;
	logic [TW-1:0]      texc_q;
	logic [47:0]        dd_sq_q;
	logic [31:0]        den_q;
	logic [8:0]         fog_q;
	logic               out_v_q;
	logic [95:0]        out_q;

	logic [19:0] rabs_x, rabs_y;
	assign rabs_x = rx_q[19] ? 20'(-rx_q) : 20'(rx_q);
	assign rabs_y = ry_q[19] ? 20'(-ry_q) : 20'(ry_q);

	// cam numerator and its magnitude
	logic signed [12:0] cnum;
	assign cnum = $signed({2'b0, col_q, 1'b0}) - 13'(SCREEN_W);
	logic [12:0] cmag;
	assign cmag = cnum[12] ? 13'(-cnum) : 13'(cnum);

	// reciprocal estimate is low by at most one
	logic [31:0] cam_rem;
	assign cam_rem = {3'd0, cmag, 16'd0} - 32'(camq0_q) * 32'(SCREEN_W);
	logic [28:0] cam_mag;
	assign cam_mag = camq0_q + 29'(cam_rem >= 32'(SCREEN_W));

	logic signed [37:0] pcx, pcy;
	assign pcx = plane_x_q * cam_q;
	assign pcy = plane_y_q * cam_q;

	logic [16:0] fx, fy;
	assign fx = rx_q[19] ? {1'b0, pos_x_q[15:0]} : 17'(65536) - {1'b0, pos_x_q[15:0]};
	assign fy = ry_q[19] ? {1'b0, pos_y_q[15:0]} : 17'(65536) - {1'b0, pos_y_q[15:0]};

	logic step_x;
	assign step_x = sdx_q < sdy_q;
	logic signed [9:0] nmx, nmy;
	assign nmx = mx_q + (rx_q[19] ? -10'sd1 : 10'sd1);
	assign nmy = my_q + (ry_q[19] ? -10'sd1 : 10'sd1);

	logic inb;
	assign inb = !mx_q[9] && !my_q[9] && (32'(mx_q) < MAP_W) && (32'(my_q) < MAP_H);
	assign ram_raddr = AW'(32'(my_q) * MAP_W + 32'(mx_q));

	logic [56:0] dsel;
	assign dsel = side_q ? (sdy_q - 57'(ddy_q)) : (sdx_q - 57'(ddx_q));

	logic signed [44:0] hprod;
	assign hprod = $signed({1'b0, d_q}) * (side_q ? rx_q : ry_q);
	logic [20:0] hpos;
	assign hpos = side_q ? pos_x_q : pos_y_q;
	logic [15:0] hfrac;
	assign hfrac = 16'(hpos + 21'(hprod >>> 16));

	logic [15:0] lh_half;
	assign lh_half = lh_q >> 1;
	logic [16:0] ds_v, de_v;
	assign ds_v = (17'(SCREEN_H / 2) > 17'(lh_half)) ? 17'(SCREEN_H / 2) - 17'(lh_half) : '0;
	assign de_v = (17'(SCREEN_H / 2) + 17'(lh_half) > 17'(SCREEN_H)) ? 17'(SCREEN_H)
		: 17'(SCREEN_H / 2) + 17'(lh_half);

	logic [16:0] lit1;
	assign lit1 = 17'((18'(fog_q) * SIDE_DIM + 128) >> 8);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_CLR;
			clr_q   <= '0;
			out_v_q <= 1'b0;
			dstart_q <= 1'b0;
		end else begin
			dstart_q <= 1'b0;
			if (out_v_q && m_tready)
				out_v_q <= 1'b0;
			case (st_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (AW+1)'(NCELL - 1))
						st_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (acc && s_tuser == OP_CAST)
						st_q <= ST_CAM;
				end
				ST_CAM: st_q <= ST_CAMF;
				ST_CAMF: st_q <= ST_RAY;
				ST_RAY: begin
					dstart_q <= 1'b1;
					st_q     <= ST_DDX;
				end
				ST_DDX: if (ddone) begin
					dstart_q <= 1'b1;
					st_q     <= ST_DDY;
				end
				ST_DDY: if (ddone) st_q <= ST_SIDE;
				ST_SIDE: st_q <= ST_STEP;
				ST_STEP: st_q <= ST_READ;
				ST_READ: st_q <= ST_HIT;
				ST_HIT: begin
					if ((inb ? ram_rdata : 3'd2) != 3'd0 || steps_q == SW'(MAX_STEPS))
						st_q <= ST_DIST;
					else
						st_q <= ST_STEP;
				end
				ST_DIST: begin
					dstart_q <= 1'b1;
					st_q     <= ST_LH;
				end
				ST_LH: if (ddone) st_q <= ST_FOG1;
				ST_FOG1: st_q <= ST_FOG2;
				ST_FOG2: begin
					dstart_q <= 1'b1;
					st_q     <= ST_FOGD;
				end
				ST_FOGD: if (ddone) st_q <= ST_OUT;
				ST_OUT: begin
					out_v_q <= 1'b1;
					st_q    <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// divider requests and datapath
	always_comb begin
		dreq.start = dstart_q;
		dreq.num   = '0;
		dreq.den   = 50'd1;
		case (st_q)
			ST_DDX: begin
				dreq.num = 64'd1 << 32;
				dreq.den = 50'(rabs_x);
			end
			ST_DDY: begin
				dreq.num = 64'd1 << 32;
				dreq.den = 50'(rabs_y);
			end
			ST_LH: begin
				dreq.num = 64'(SCREEN_H) << 16;
				dreq.den = 50'(d_q);
			end
			ST_FOGD: begin
				dreq.num = 64'((33'd1 << 24) + 33'(den_q >> 1));
				dreq.den = 50'(den_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: if (acc) begin
				col_q     <= in_col;
				mx_q      <= '0;
				steps_q   <= '0;
				side_q    <= 1'b0;
			end
			ST_CAM: camq0_q <= 29'((61'({cmag, 16'd0}) * 61'(CAM_RCP)) >> 32);
			ST_CAMF: cam_q <= cnum[12] ? -18'(cam_mag) : 18'(cam_mag);
			ST_RAY: begin
				rx_q <= 20'(dir_x_q) + 20'(pcx >>> 16);
				ry_q <= 20'(dir_y_q) + 20'(pcy >>> 16);
			end
			ST_DDX: if (ddone) ddx_q <= (rabs_x == 0) ? 49'd1 << 48 : 49'(dquo);
			ST_DDY: if (ddone) ddy_q <= (rabs_y == 0) ? 49'd1 << 48 : 49'(dquo);
			ST_SIDE: begin
				sdx_q <= (rx_q == 0) ? 57'd1 << 48
					: 57'((50'(fx) * 50'(ddx_q[32:0])) >> 16);
				sdy_q <= (ry_q == 0) ? 57'd1 << 48
					: 57'((50'(fy) * 50'(ddy_q[32:0])) >> 16);
				mx_q  <= 10'(pos_x_q >> 16);
				my_q  <= 10'(pos_y_q >> 16);
			end
			ST_STEP: begin
				steps_q <= steps_q + 1'b1;
				if (step_x) begin
					sdx_q <= sdx_q + 57'(ddx_q);
					mx_q  <= nmx;
					side_q <= 1'b0;
				end else begin
					sdy_q <= sdy_q + 57'(ddy_q);
					my_q  <= nmy;
					side_q <= 1'b1;
				end
			end
			ST_HIT: type_q <= inb ? ram_rdata : 3'd2;
			ST_DIST: begin
				if (dsel[56] || dsel == 0)
					d_q <= 24'd1;
				else if (dsel > 57'(DIST_MAX))
					d_q <= 24'(DIST_MAX);
				else
					d_q <= 24'(dsel);
			end
			ST_LH: if (ddone)
				lh_q <= (dquo > 64'd65535) ? 16'hFFFF : 16'(dquo);
			ST_FOG1: begin
				dd_sq_q <= 48'(d_q) * 48'(d_q);
				texc_q  <= TW'((32'(hfrac) * TEX_SIZE) >> 16);
			end
			ST_FOG2: begin
				den_q <= 32'd65536 + 32'((48'(FOG_LIN) * 48'(d_q)) >> 16)
					+ 32'((64'(FOG_QUAD) * 64'(dd_sq_q >> 16)) >> 16);
				if ((!side_q && rx_q > 0) || (side_q && ry_q[19]))
					texc_q <= TW'(TEX_SIZE - 1) - texc_q;
			end
			ST_FOGD: if (ddone) fog_q <= 9'(dquo);
			ST_OUT: begin
				out_q <= {7'd0, d_q,
					side_q ? 9'(lit1) : fog_q,
					6'(texc_q), lh_q, 10'(de_v), 10'(ds_v), side_q,
					(type_q >= 3'd1 && type_q <= 3'd5) ? type_q : 3'd2, col_q};
			end
			default: ;
		endcase
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_q;

	unused_guard: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_CLR) |-> !s_tready) else $error("ready during clear");
	a_one_out: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready) else $error("accept while result pending");
	a_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_HIT) |-> steps_q <= SW'(MAX_STEPS)) else $error("walk overran");
	a_dist: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_LH) |-> d_q != 24'd0) else $error("zero distance");
endmodule

/* bench/grid_ray_wall_caster_unit_tb.sv */
// Self-checking bench for the grid ray wall caster: map writes, column casts, camera setups.
module grid_ray_wall_caster_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import grc_pkg::*;

	localparam int  MW        = 32;
	localparam int  MH        = 32;
	localparam int  SW        = 960;
	localparam int  SH        = 540;
	localparam int  TEXSZ     = 64;
	localparam int  STEPS     = 128;
	localparam longint NO_STEP = 64'd1 << 48;
	localparam longint CYCLE_LIMIT = 4000000;

	typedef struct packed {
		logic [23:0] wall_distance;
		logic [8:0]  light_level;
		logic [5:0]  tex_column;
		logic [15:0] line_height;
		logic [9:0]  draw_end;
		logic [9:0]  draw_start;
		logic        hit_side;
		logic [2:0]  wall_texture;
		logic [9:0]  column_out;
	} column_t;

	class column_scoreboard;
		logic [2:0]  map_cells [MW*MH];
		logic [20:0] pos_x, pos_y;
		logic [17:0] dir_x, dir_y, plane_x, plane_y;
		column_t     pending [$];
		int          errors;
		int          casts_checked;

		function new();
			foreach (map_cells[i])
				map_cells[i] = 3'd0;
			pos_x   = 21'd163840;
			pos_y   = 21'd819200;
			dir_x   = 18'd65536;
			dir_y   = 18'd0;
			plane_x = 18'd0;
			plane_y = 18'(-43254);
			errors  = 0;
			casts_checked = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [20:0] val);
			case (idx)
				REG_POS_X:   pos_x   = val;
				REG_POS_Y:   pos_y   = val;
				REG_DIR_X:   dir_x   = val[17:0];
				REG_DIR_Y:   dir_y   = val[17:0];
				REG_PLANE_X: plane_x = val[17:0];
				REG_PLANE_Y: plane_y = val[17:0];
				default: ;
			endcase
		endfunction

		function longint cell_at(longint x, longint y);
			if (x < 0 || x >= MW || y < 0 || y >= MH)
				return 2;
			return longint'(map_cells[y*MW + x]);
		endfunction

		function longint step_len(longint r);
			longint a;
			a = r < 0 ? -r : r;
			if (a == 0)
				return NO_STEP;
			return (64'sd1 <<< 32) / a;
		endfunction

		function longint first_side(longint r, logic [20:0] p, longint dd);
			longint f;
			f = longint'(p[15:0]);
			if (r == 0)
				return NO_STEP;
			if (r > 0)
				f = 65536 - f;
			return (f * dd) >>> 16;
		endfunction

		function column_t cast_column(logic [9:0] col_in);
			column_t res;
			longint col, cam, rx, ry, ddx, ddy, sdx, sdy, mx, my, sx, sy;
			longint d, lh, ds, de, hit, texc, den, fog, light, ctype;
			int side;
			col   = longint'(col_in);
			cam   = ((2*col - SW) * 65536) / SW;
			rx    = longint'($signed(dir_x)) + ((longint'($signed(plane_x)) * cam) >>> 16);
			ry    = longint'($signed(dir_y)) + ((longint'($signed(plane_y)) * cam) >>> 16);
			mx    = longint'(pos_x[20:16]);
			my    = longint'(pos_y[20:16]);
			ddx   = step_len(rx);
			ddy   = step_len(ry);
			sdx   = first_side(rx, pos_x, ddx);
			sdy   = first_side(ry, pos_y, ddy);
			sx    = rx < 0 ? -1 : 1;
			sy    = ry < 0 ? -1 : 1;
			side  = 0;
			ctype = 2;
			for (int i = 0; i < STEPS; i++) begin
				if (sdx < sdy) begin
					sdx += ddx; mx += sx; side = 0;
				end else begin
					sdy += ddy; my += sy; side = 1;
				end
				ctype = cell_at(mx, my);
				if (ctype > 0)
					break;
			end
			d = side == 0 ? sdx - ddx : sdy - ddy;
			if (d < 1) d = 1;
			if (d > DIST_MAX) d = DIST_MAX;
			lh = (longint'(SH) <<< 16) / d;
			if (lh > 65535) lh = 65535;
			ds = SH/2 - lh/2;
			de = SH/2 + lh/2;
			if (ds < 0) ds = 0;
			if (de > SH) de = SH;
			hit = side == 0 ? longint'(pos_y) + ((d * ry) >>> 16)
			                : longint'(pos_x) + ((d * rx) >>> 16);
			texc = ((hit & 64'hFFFF) * TEXSZ) >>> 16;
			if ((side == 0 && rx > 0) || (side == 1 && ry < 0))
				texc = TEXSZ - 1 - texc;
			den   = 65536 + ((FOG_LIN * d) >>> 16) + ((FOG_QUAD * ((d * d) >>> 16)) >>> 16);
			fog   = ((64'sd1 <<< 24) + den/2) / den;
			light = side == 1 ? (fog * SIDE_DIM + 128) >>> 8 : fog;
			res.column_out    = col_in;
			res.wall_texture  = (ctype >= 1 && ctype <= 5) ? 3'(ctype) : 3'd2;
			res.hit_side      = 1'(side);
			res.draw_start    = 10'(ds);
			res.draw_end      = 10'(de);
			res.line_height   = 16'(lh);
			res.tex_column    = 6'(texc);
			res.light_level   = 9'(light);
			res.wall_distance = 24'(d);
			return res;
		endfunction

		function void note_item(logic op, logic [23:0] data);
			if (op == OP_WRITE)
				map_cells[data[9:5]*MW + data[4:0]] = data[12:10];
			else
				pending.push_back(cast_column(data[22:13]));
		endfunction

		task report(string what, longint got, longint want, logic [9:0] col);
			errors++;
			$display("mismatch col %0d %s: got %0d expected %0d", col, what, got, want);
		endtask

		task check_result(logic [95:0] raw);
			column_t got, want;
			got = column_t'(raw[88:0]);
			if (pending.size() == 0) begin
				errors++;
				$display("unexpected result for col %0d", got.column_out);
				return;
			end
			want = pending.pop_front();
			casts_checked++;
			if (got.column_out != want.column_out)
				report("column_out", got.column_out, want.column_out, want.column_out);
			if (got.wall_texture != want.wall_texture)
				report("wall_texture", got.wall_texture, want.wall_texture, want.column_out);
			if (got.hit_side != want.hit_side)
				report("hit_side", got.hit_side, want.hit_side, want.column_out);
			if (got.draw_start != want.draw_start)
				report("draw_start", got.draw_start, want.draw_start, want.column_out);
			if (got.draw_end != want.draw_end)
				report("draw_end", got.draw_end, want.draw_end, want.column_out);
			if (got.line_height != want.line_height)
				report("line_height", got.line_height, want.line_height, want.column_out);
			if (got.tex_column != want.tex_column)
				report("tex_column", got.tex_column, want.tex_column, want.column_out);
			if (got.light_level != want.light_level)
				report("light_level", got.light_level, want.light_level, want.column_out);
			if (got.wall_distance != want.wall_distance)
				report("wall_distance", got.wall_distance, want.wall_distance,
					want.column_out);
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = REG_POS_X;
	logic [20:0] cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic        s_tuser = OP_WRITE;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [95:0] m_tdata;

	column_scoreboard sb = new();
	longint cycles = 0;
	int     writes_sent = 0;
	int     casts_sent = 0;
	int     burst_left = 0;
	logic [7:0] ready_pattern = 8'hFF;

	grid_ray_wall_caster_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("TEST FAILED");
			$finish;
		end
	end

	// receiver stall pattern, reshuffled now and then
	always @(posedge clk) begin
		if ($urandom_range(0, 149) == 0) begin
			if ($urandom_range(0, 2) == 0)
				ready_pattern <= 8'hFF;
			else
				ready_pattern <= 8'($urandom) | 8'h01;
		end else begin
			ready_pattern <= {ready_pattern[0], ready_pattern[7:1]};
		end
		m_tready <= ready_pattern[0];
	end

	always @(posedge clk)
		if (m_tvalid && m_tready)
			sb.check_result(m_tdata);

	task send_item(logic op, logic [23:0] data);
		int gap;
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= data;
		do @(posedge clk); while (!s_tready);
		sb.note_item(op, data);
		if (op == OP_CAST)
			casts_sent++;
		else
			writes_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task put_cell(int x, int y, int kind);
		send_item(OP_WRITE, {11'd0, 3'(kind), 5'(y), 5'(x)});
	endtask

	task cast(int col);
		send_item(OP_CAST, {1'b0, 10'(col), 13'd0});
	endtask

	task drain();
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task set_camera(logic [20:0] px, logic [20:0] py, int dx, int dy, int plx, int ply);
		logic [20:0] vals [6];
		logic [2:0]  idx  [6];
		vals = '{px, py, 21'(dx), 21'(dy), 21'(plx), 21'(ply)};
		idx  = '{REG_POS_X, REG_POS_Y, REG_DIR_X, REG_DIR_Y, REG_PLANE_X, REG_PLANE_Y};
		drain();
		for (int i = 0; i < 6; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= vals[i];
			@(posedge clk);
			sb.set_reg(idx[i], vals[i]);
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task random_phase(int count);
		for (int i = 0; i < count; i++) begin
			if (i == count/2 && $urandom_range(0, 1) == 0)
				drain();
			if ($urandom_range(0, 1) == 0)
				put_cell($urandom_range(0, 31), $urandom_range(0, 31),
					$urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 7));
			else
				cast($urandom_range(0, 1023));
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset camera: straight ray at the center column, edges, beyond the screen
		cast(480);
		cast(0);
		cast(959);
		cast(1023);
		put_cell(3, 12, 7);
		put_cell(31, 31, 5);
		put_cell(0, 0, 1);
		put_cell(6, 12, 4);
		cast(480);
		cast(0);
		cast(700);
		put_cell(3, 12, 0);
		cast(480);
		for (int k = 1; k <= 6; k++)
			put_cell(k + 8, k + 10, k);
		cast(300);
		drain();

		// both ray components zero
		set_camera(21'd163840, 21'd819200, 0, 0, 0, 0);
		cast(480);
		cast(100);
		// extreme position and vectors
		set_camera(21'h1FFFFF, 21'd0, -131072, 131071, 131071, -131072);
		cast(0);
		cast(959);
		cast(511);
		set_camera(21'd0, 21'h1FFFFF, 131071, -131072, -131072, 131071);
		cast(0);
		cast(1023);

		for (int ph = 0; ph < 10; ph++) begin
			if (ph % 3 == 0)
				set_camera($urandom_range(0, 2097151), $urandom_range(0, 2097151),
					$urandom_range(0, 262143), $urandom_range(0, 262143),
					$urandom_range(0, 262143), $urandom_range(0, 262143));
			else
				set_camera($urandom_range(65536, 2031615), $urandom_range(65536, 2031615),
					$urandom_range(0, 131072) - 65536, $urandom_range(0, 131072) - 65536,
					$urandom_range(0, 90000) - 45000, $urandom_range(0, 90000) - 45000);
			random_phase(132);
		end
		drain();
		repeat (200) @(posedge clk);

		$display("covered %0d map writes and %0d casts over 14 camera setups",
			writes_sent, casts_sent);
		$display("%0d results checked, %0d mismatches", sb.casts_checked, sb.errors);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
